@@ hdl/assert_macros.svh @@
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A condition that holds at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (cond)) \
        else $error(msg);

// A condition that holds in the same cycle whenever the trigger holds.
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// A condition that holds in the cycle after the trigger.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/swin_pkg.sv @@
`default_nettype none

package swin_pkg;

    // Block dimensions.
    localparam int NUM_RECEIVERS = 4;
    localparam int WINDOW_SIZE   = 8;
    localparam int PAYLOAD_BYTES = 48;
    localparam int NUM_SLOTS     = NUM_RECEIVERS * WINDOW_SIZE;

    // Field and index widths.
    localparam int SEQ_W    = 8;
    localparam int TMR_W    = 16;
    localparam int ID_W     = 8;
    localparam int RCVF_W   = 4;
    localparam int STATUS_W = 4;
    localparam int RCV_W    = (NUM_RECEIVERS > 1) ? $clog2(NUM_RECEIVERS) : 1;
    localparam int CNT_W    = $clog2(WINDOW_SIZE + 1);
    localparam int ADDR_W   = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

    // Configuration port.
    localparam int APB_AW = 3;
    localparam int APB_DW = 32;
    localparam logic [TMR_W-1:0] TIMEOUT_RESET = TMR_W'(100);

    typedef enum logic [1:0] {
        OP_SEND = 2'd0,
        OP_ACK  = 2'd1,
        OP_TICK = 2'd2
    } t_opcode;

    typedef enum logic [STATUS_W-1:0] {
        ST_SENT      = 4'd0,
        ST_RETX      = 4'd1,
        ST_ACK_SLID  = 4'd2,
        ST_ACK_STALE = 4'd3,
        ST_CORRUPT   = 4'd4,
        ST_NOT_ACK   = 4'd5,
        ST_OTHER_TGT = 4'd6,
        ST_BAD_RCV   = 4'd7,
        ST_WIN_FULL  = 4'd8,
        ST_TOO_LONG  = 4'd9
    } t_status;

    typedef enum logic [0:0] {
        REG_OWN_ID  = 1'b0,
        REG_TIMEOUT = 1'b1
    } t_reg_idx;

    // Settings the sequencer needs from the register file.
    typedef struct packed {
        logic [ID_W-1:0]  own_id;
        logic [TMR_W-1:0] arm;
    } t_cfg;

    // One access cycle of the timer memory.
    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [TMR_W-1:0]  wdata;
        logic [ADDR_W-1:0] raddr;
    } t_mem_req;

    // Memory address of slot k in the window of receiver r.
    function automatic logic [ADDR_W-1:0] slot_addr(input logic [RCV_W-1:0] r,
                                                   input logic [CNT_W-1:0] k);
        slot_addr = ADDR_W'(int'(r) * WINDOW_SIZE + int'(k));
    endfunction

endpackage

`default_nettype wire

@@ hdl/swin_alu.sv @@
`default_nettype none

// Shared subtractor: window fill, ack distance and timer countdown all use it.
module swin_alu (
    input  wire logic [swin_pkg::TMR_W-1:0] i_a,
    input  wire logic [swin_pkg::TMR_W-1:0] i_b,
    output logic      [swin_pkg::TMR_W-1:0] o_diff,
    output logic                            o_zero
);

    // Modulo difference and its zero flag.
    assign o_diff = i_a - i_b;
    assign o_zero = (o_diff == '0);

endmodule

`default_nettype wire

@@ hdl/swin_tmem.sv @@
`default_nettype none

// Timer memory: one write and one registered read per cycle.
// Entries never written since reset read as zero (idle slot).
module swin_tmem (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire swin_pkg::t_mem_req         i_req,
    output logic [swin_pkg::TMR_W-1:0]      o_rdata
);

    logic [swin_pkg::TMR_W-1:0] r_mem [swin_pkg::NUM_SLOTS];
    logic [swin_pkg::NUM_SLOTS-1:0] r_valid;
    logic [swin_pkg::TMR_W-1:0] r_rdata;
    logic                       r_rd_valid;

    // Storage and read data register.
    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        r_rdata <= r_mem[i_req.raddr];
    end

    // Per-entry written flags, cleared at reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            if (i_req.we) begin
                r_valid[i_req.waddr] <= 1'b1;
            end
            r_rd_valid <= r_valid[i_req.raddr];
        end
    end

    assign o_rdata = r_rd_valid ? r_rdata : '0;

endmodule

`default_nettype wire

@@ hdl/swin_cfg.sv @@
`default_nettype none

// Register file behind the APB port.
module swin_cfg (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_psel,
    input  wire logic                          i_penable,
    input  wire logic                          i_pwrite,
    input  wire logic [swin_pkg::APB_AW-1:0]   i_paddr,
    input  wire logic [swin_pkg::APB_DW-1:0]   i_pwdata,
    output logic      [swin_pkg::APB_DW-1:0]   o_prdata,
    output swin_pkg::t_cfg                     o_cfg
);

    logic [swin_pkg::ID_W-1:0]  r_own_id;
    logic [swin_pkg::TMR_W-1:0] r_timeout;
    logic                       wr_en;
    swin_pkg::t_reg_idx         reg_idx;

    assign wr_en   = i_psel && i_penable && i_pwrite;
    assign reg_idx = swin_pkg::t_reg_idx'(i_paddr[2]);

    // Register writes in the access phase.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_own_id  <= '0;
            r_timeout <= swin_pkg::TIMEOUT_RESET;
        end else if (wr_en) begin
            case (reg_idx)
                swin_pkg::REG_OWN_ID:  r_own_id  <= i_pwdata[swin_pkg::ID_W-1:0];
                swin_pkg::REG_TIMEOUT: r_timeout <= i_pwdata[swin_pkg::TMR_W-1:0];
                default: ;
            endcase
        end
    end

    // Read mux.
    always_comb begin
        case (reg_idx)
            swin_pkg::REG_OWN_ID:  o_prdata = swin_pkg::APB_DW'(r_own_id);
            swin_pkg::REG_TIMEOUT: o_prdata = swin_pkg::APB_DW'(r_timeout);
            default:               o_prdata = '0;
        endcase
    end

    // A zero timeout still arms a timer for one tick.
    assign o_cfg.own_id = r_own_id;
    assign o_cfg.arm    = (r_timeout == '0) ? swin_pkg::TMR_W'(1) : r_timeout;

endmodule

`default_nettype wire

@@ hdl/sliding_window_sender.sv @@
`default_nettype none
// Sliding-window sender control for NUM_RECEIVERS receivers of WINDOW_SIZE slots.
// Commands enter on start while busy is low: opcode 0 sends, 1 delivers an ack
// frame, 2 is a timer tick; opcode 3 is taken and dropped. Each result word
// appears on o_status, o_receiver, o_sequence_res and o_last for one cycle,
// marked by o_strobe; the receiver always takes it. o_last marks the final word.
// Steps of each command:
//   send, or an ack that fails its frame checks: S_SEND or S_ACK, then the word;
//   stale ack: S_ACK, S_ACK_CHK; sliding ack: then S_SLIDE_RD/_WR for each slot;
//   tick: S_TICK_N, then S_TICK_RD/_UPD per outstanding frame, for each receiver.
// Retransmit words of a tick come out while it runs, the last one after the scan.
// The timer memory is walked slot by slot, a read and then a write-back for each,
// with the tick countdown through the single shared subtractor.
// The APB port holds own_sender_id at 0x0 and timeout_ticks at 0x4; write it
// only while busy is low. Reset is synchronous: windows empty, all timers idle,
// timeout 100 ticks, sender id 0. Reset needs no clearing pass.
module sliding_window_sender (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic [1:0]                    i_opcode,
    input  wire logic [7:0]                    i_dest_receiver,
    input  wire logic [7:0]                    i_message_length,
    input  wire logic                          i_crc_good,
    input  wire logic                          i_ack_flag_set,
    input  wire logic [7:0]                    i_ack_target,
    input  wire logic [7:0]                    i_ack_source,
    input  wire logic [7:0]                    i_ack_number,
    output logic                               o_strobe,
    output logic [3:0]                         o_status,
    output logic [3:0]                         o_receiver,
    output logic [7:0]                         o_sequence_res,
    output logic                               o_last,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [swin_pkg::APB_AW-1:0]   paddr,
    input  wire logic [swin_pkg::APB_DW-1:0]   pwdata,
    output logic      [swin_pkg::APB_DW-1:0]   prdata,
    output logic                               pready
);

    `include "assert_macros.svh"

    typedef enum logic [3:0] {
        S_IDLE,
        S_SEND,
        S_ACK,
        S_ACK_CHK,
        S_SLIDE_RD,
        S_SLIDE_WR,
        S_TICK_N,
        S_TICK_RD,
        S_TICK_UPD,
        S_TICK_END
    } t_state;

    swin_pkg::t_cfg     cfg;
    swin_pkg::t_mem_req mem_req;
    logic [swin_pkg::TMR_W-1:0] mem_rdata;
    logic [swin_pkg::TMR_W-1:0] alu_a, alu_b, alu_diff;
    logic                       alu_zero;

    t_state r_state, n_state;
    logic [7:0] r_dest, n_dest, r_len, n_len, r_target, n_target;
    logic [7:0] r_src, n_src, r_ackno, n_ackno;
    logic       r_crc, n_crc, r_flag, n_flag;
    logic [swin_pkg::SEQ_W-1:0] r_lar [swin_pkg::NUM_RECEIVERS];
    logic [swin_pkg::SEQ_W-1:0] n_lar [swin_pkg::NUM_RECEIVERS];
    logic [swin_pkg::SEQ_W-1:0] r_lfs [swin_pkg::NUM_RECEIVERS];
    logic [swin_pkg::SEQ_W-1:0] n_lfs [swin_pkg::NUM_RECEIVERS];
    logic [swin_pkg::SEQ_W-1:0] r_d, n_d;
    logic [swin_pkg::CNT_W-1:0] r_k, n_k, r_n, n_n;
    logic [swin_pkg::RCV_W-1:0] r_r, n_r;
    logic                       r_in_win, n_in_win;
    logic                       r_pend_v, n_pend_v;
    logic [swin_pkg::RCV_W-1:0] r_pend_rcv, n_pend_rcv;
    logic [swin_pkg::SEQ_W-1:0] r_pend_seq, n_pend_seq;
    logic                       r_strobe, n_strobe, r_last, n_last;
    swin_pkg::t_status          r_status, n_status;
    logic [swin_pkg::RCVF_W-1:0] r_rcv, n_rcv;
    logic [swin_pkg::SEQ_W-1:0] r_seq, n_seq;

    logic                       dest_ok, src_ok;
    logic [swin_pkg::RCV_W-1:0] dest_idx, src_idx;
    logic [swin_pkg::SEQ_W-1:0] fill;
    logic [swin_pkg::SEQ_W:0]   slide_src;

    logic                       final_word, early_word, is_retx, seqless_word;
    logic                       cmd_taken, scan_ok;

    swin_cfg u_cfg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_psel    (psel),
        .i_penable (penable),
        .i_pwrite  (pwrite),
        .i_paddr   (paddr),
        .i_pwdata  (pwdata),
        .o_prdata  (prdata),
        .o_cfg     (cfg)
    );

    swin_tmem u_tmem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mem_req),
        .o_rdata (mem_rdata)
    );

    swin_alu u_alu (
        .i_a    (alu_a),
        .i_b    (alu_b),
        .o_diff (alu_diff),
        .o_zero (alu_zero)
    );

    assign pready = 1'b1;
    assign busy   = (r_state != S_IDLE);

    assign dest_ok   = (r_dest < 8'(swin_pkg::NUM_RECEIVERS));
    assign src_ok    = (r_src < 8'(swin_pkg::NUM_RECEIVERS));
    assign dest_idx  = r_dest[swin_pkg::RCV_W-1:0];
    assign src_idx   = r_src[swin_pkg::RCV_W-1:0];
    assign fill      = alu_diff[swin_pkg::SEQ_W-1:0];
    assign slide_src = {1'b0, r_d} + (swin_pkg::SEQ_W + 1)'(r_k);

    // Sequencer: next state, window pointers, memory access and result word.
    always_comb begin
        n_state    = r_state;
        n_dest     = r_dest;
        n_len      = r_len;
        n_target   = r_target;
        n_src      = r_src;
        n_ackno    = r_ackno;
        n_crc      = r_crc;
        n_flag     = r_flag;
        n_lar      = r_lar;
        n_lfs      = r_lfs;
        n_d        = r_d;
        n_k        = r_k;
        n_n        = r_n;
        n_r        = r_r;
        n_in_win   = r_in_win;
        n_pend_v   = r_pend_v;
        n_pend_rcv = r_pend_rcv;
        n_pend_seq = r_pend_seq;
        n_strobe   = 1'b0;
        n_last     = r_last;
        n_status   = r_status;
        n_rcv      = r_rcv;
        n_seq      = r_seq;
        mem_req    = '0;
        alu_a      = '0;
        alu_b      = '0;

        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_dest   = i_dest_receiver;
                    n_len    = i_message_length;
                    n_crc    = i_crc_good;
                    n_flag   = i_ack_flag_set;
                    n_target = i_ack_target;
                    n_src    = i_ack_source;
                    n_ackno  = i_ack_number;
                    case (swin_pkg::t_opcode'(i_opcode))
                        swin_pkg::OP_SEND: n_state = S_SEND;
                        swin_pkg::OP_ACK:  n_state = S_ACK;
                        swin_pkg::OP_TICK: begin
                            n_r      = '0;
                            n_pend_v = 1'b0;
                            n_state  = S_TICK_N;
                        end
                        default: n_state = S_IDLE;
                    endcase
                end
            end

            // Length, receiver and window checks, then claim the next sequence.
            S_SEND: begin
                alu_a    = swin_pkg::TMR_W'(r_lfs[dest_idx]);
                alu_b    = swin_pkg::TMR_W'(r_lar[dest_idx]);
                n_strobe = 1'b1;
                n_last   = 1'b1;
                n_seq    = '0;
                n_rcv    = dest_ok ? swin_pkg::RCVF_W'(r_dest) : '0;
                n_state  = S_IDLE;
                if (r_len > 8'(swin_pkg::PAYLOAD_BYTES)) begin
                    n_status = swin_pkg::ST_TOO_LONG;
                end else if (!dest_ok) begin
                    n_status = swin_pkg::ST_BAD_RCV;
                end else if (fill >= swin_pkg::SEQ_W'(swin_pkg::WINDOW_SIZE)) begin
                    n_status = swin_pkg::ST_WIN_FULL;
                end else begin
                    n_lfs[dest_idx] = r_lfs[dest_idx] + 1'b1;
                    mem_req.we      = 1'b1;
                    mem_req.waddr   = swin_pkg::slot_addr(dest_idx,
                                                          swin_pkg::CNT_W'(fill));
                    mem_req.wdata   = cfg.arm;
                    n_status        = swin_pkg::ST_SENT;
                    n_seq           = r_lfs[dest_idx] + 1'b1;
                end
            end

            // Frame checks, then distance of the ack from the window base.
            S_ACK: begin
                n_strobe = 1'b1;
                n_last   = 1'b1;
                n_seq    = '0;
                n_rcv    = '0;
                n_state  = S_IDLE;
                if (!r_crc) begin
                    n_status = swin_pkg::ST_CORRUPT;
                end else if (!r_flag) begin
                    n_status = swin_pkg::ST_NOT_ACK;
                end else if (r_target != cfg.own_id) begin
                    n_status = swin_pkg::ST_OTHER_TGT;
                end else if (!src_ok) begin
                    n_status = swin_pkg::ST_BAD_RCV;
                end else begin
                    alu_a    = swin_pkg::TMR_W'(r_ackno);
                    alu_b    = swin_pkg::TMR_W'(r_lar[src_idx]);
                    n_d      = fill;
                    n_strobe = 1'b0;
                    n_state  = S_ACK_CHK;
                end
            end

            // The ack must fall inside the open window.
            S_ACK_CHK: begin
                alu_a = swin_pkg::TMR_W'(r_lfs[src_idx]);
                alu_b = swin_pkg::TMR_W'(r_lar[src_idx]);
                if (r_d == '0 || r_d > fill) begin
                    n_strobe = 1'b1;
                    n_last   = 1'b1;
                    n_seq    = '0;
                    n_rcv    = swin_pkg::RCVF_W'(r_src);
                    n_status = swin_pkg::ST_ACK_STALE;
                    n_state  = S_IDLE;
                end else begin
                    n_k     = '0;
                    n_state = S_SLIDE_RD;
                end
            end

            // Shift the timers down by the ack distance, one slot per pass.
            S_SLIDE_RD: begin
                n_in_win      = (slide_src < (swin_pkg::SEQ_W + 1)'(swin_pkg::WINDOW_SIZE));
                mem_req.raddr = swin_pkg::slot_addr(src_idx, swin_pkg::CNT_W'(slide_src));
                n_state       = S_SLIDE_WR;
            end

            S_SLIDE_WR: begin
                mem_req.we    = 1'b1;
                mem_req.waddr = swin_pkg::slot_addr(src_idx, r_k);
                mem_req.wdata = r_in_win ? mem_rdata : '0;
                if (r_k == swin_pkg::CNT_W'(swin_pkg::WINDOW_SIZE - 1)) begin
                    n_lar[src_idx] = r_ackno;
                    n_strobe       = 1'b1;
                    n_last         = 1'b1;
                    n_seq          = '0;
                    n_rcv          = swin_pkg::RCVF_W'(r_src);
                    n_status       = swin_pkg::ST_ACK_SLID;
                    n_state        = S_IDLE;
                end else begin
                    n_k     = r_k + 1'b1;
                    n_state = S_SLIDE_RD;
                end
            end

            // Outstanding frames of the current receiver, capped at the window.
            S_TICK_N: begin
                alu_a = swin_pkg::TMR_W'(r_lfs[r_r]);
                alu_b = swin_pkg::TMR_W'(r_lar[r_r]);
                if (fill > swin_pkg::SEQ_W'(swin_pkg::WINDOW_SIZE)) begin
                    n_n = swin_pkg::CNT_W'(swin_pkg::WINDOW_SIZE);
                end else begin
                    n_n = swin_pkg::CNT_W'(fill);
                end
                n_k     = '0;
                n_state = S_TICK_RD;
            end

            S_TICK_RD: begin
                if (r_k >= r_n) begin
                    if (r_r == swin_pkg::RCV_W'(swin_pkg::NUM_RECEIVERS - 1)) begin
                        n_state = S_TICK_END;
                    end else begin
                        n_r     = r_r + 1'b1;
                        n_state = S_TICK_N;
                    end
                end else begin
                    mem_req.raddr = swin_pkg::slot_addr(r_r, r_k);
                    n_state       = S_TICK_UPD;
                end
            end

            // Count an armed timer down; on expiry rearm it and queue a word.
            // The queued word goes out when the next one shows up or at the end,
            // so the final word of the tick can carry the last flag.
            S_TICK_UPD: begin
                alu_a = mem_rdata;
                alu_b = swin_pkg::TMR_W'(1);
                if (mem_rdata != '0) begin
                    mem_req.we    = 1'b1;
                    mem_req.waddr = swin_pkg::slot_addr(r_r, r_k);
                    if (alu_zero) begin
                        mem_req.wdata = cfg.arm;
                        if (r_pend_v) begin
                            n_strobe = 1'b1;
                            n_last   = 1'b0;
                            n_status = swin_pkg::ST_RETX;
                            n_rcv    = swin_pkg::RCVF_W'(r_pend_rcv);
                            n_seq    = r_pend_seq;
                        end
                        n_pend_v   = 1'b1;
                        n_pend_rcv = r_r;
                        n_pend_seq = r_lar[r_r] + 1'b1 + swin_pkg::SEQ_W'(r_k);
                    end else begin
                        mem_req.wdata = alu_diff;
                    end
                end
                n_k     = r_k + 1'b1;
                n_state = S_TICK_RD;
            end

            S_TICK_END: begin
                if (r_pend_v) begin
                    n_strobe = 1'b1;
                    n_last   = 1'b1;
                    n_status = swin_pkg::ST_RETX;
                    n_rcv    = swin_pkg::RCVF_W'(r_pend_rcv);
                    n_seq    = r_pend_seq;
                end
                n_pend_v = 1'b0;
                n_state  = S_IDLE;
            end

            default: n_state = S_IDLE;
        endcase
    end

    // State, window pointers and the result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_lar    <= '{default: '0};
            r_lfs    <= '{default: '0};
            r_k      <= '0;
            r_n      <= '0;
            r_pend_v <= 1'b0;
            r_strobe <= 1'b0;
            r_last   <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_dest     <= n_dest;
            r_len      <= n_len;
            r_target   <= n_target;
            r_src      <= n_src;
            r_ackno    <= n_ackno;
            r_crc      <= n_crc;
            r_flag     <= n_flag;
            r_lar      <= n_lar;
            r_lfs      <= n_lfs;
            r_d        <= n_d;
            r_k        <= n_k;
            r_n        <= n_n;
            r_r        <= n_r;
            r_in_win   <= n_in_win;
            r_pend_v   <= n_pend_v;
            r_pend_rcv <= n_pend_rcv;
            r_pend_seq <= n_pend_seq;
            r_strobe   <= n_strobe;
            r_last     <= n_last;
            r_status   <= n_status;
            r_rcv      <= n_rcv;
            r_seq      <= n_seq;
        end
    end

    assign o_strobe       = r_strobe;
    assign o_last         = r_last;
    assign o_status       = r_status;
    assign o_receiver     = r_rcv;
    assign o_sequence_res = r_seq;

    // Terms the checks below are built from.
    assign final_word   = o_strobe && o_last;
    assign early_word   = o_strobe && !o_last;
    assign is_retx      = (o_status == swin_pkg::ST_RETX);
    assign seqless_word = o_strobe && (o_status != swin_pkg::ST_SENT) && !is_retx;
    assign cmd_taken    = start && !busy && (i_opcode == swin_pkg::OP_SEND ||
                          i_opcode == swin_pkg::OP_ACK || i_opcode == swin_pkg::OP_TICK);
    assign scan_ok      = (r_n <= swin_pkg::CNT_W'(swin_pkg::WINDOW_SIZE));

    // The final word of a command is only shown once the block is free again.
    `ASSERT_IMPLIES(a_last_when_idle, i_clk, i_rst_n, final_word, !busy, "final word while busy")
    // Only a tick produces more than one word, so only retransmits come early.
    `ASSERT_IMPLIES(a_early_is_retx, i_clk, i_rst_n, early_word, is_retx, "early word not retx")
    // Words that assign no sequence carry zero in that field.
    `ASSERT_IMPLIES(a_seq_unused_zero, i_clk, i_rst_n, seqless_word, o_sequence_res == '0, "stray seq")
    // A real command keeps the block busy in the next cycle.
    `ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, cmd_taken, busy, "command accepted but block idle")
    // The tick scan never walks past the window.
    `ASSERT_ALWAYS(a_scan_bound, i_clk, i_rst_n, scan_ok, "tick scan count beyond window")

endmodule

`default_nettype wire

@@ sim/tb.sv @@
`timescale 1ns / 100ps

import swin_pkg::*;

// One command as it is presented on the input ports.
typedef struct {
    logic [1:0] op;
    logic [7:0] dest;
    logic [7:0] len;
    logic       crc;
    logic       flag;
    logic [7:0] tgt;
    logic [7:0] src;
    logic [7:0] ackno;
} swin_cmd_t;

// One result word as it appears on the output ports.
typedef struct {
    t_status    status;
    logic [3:0] rcv;
    logic [7:0] seq;
    logic       last;
} result_word_t;

// Tracks the per-receiver windows and slot timers, and holds the result words
// that the block still owes.
class window_result_board;
    logic [7:0]   own_id;
    logic [15:0]  timeout;
    logic [7:0]   lar [NUM_RECEIVERS];
    logic [7:0]   lfs [NUM_RECEIVERS];
    logic [15:0]  slot_tmr [NUM_SLOTS];
    result_word_t awaited_words [$];
    int           mismatches;
    int           words_checked;
    int           status_seen [16];

    function new();
        own_id = 8'd0;
        timeout = TIMEOUT_RESET;
        foreach (lar[r]) begin
            lar[r] = 8'd0;
            lfs[r] = 8'd0;
        end
        foreach (slot_tmr[s]) slot_tmr[s] = 16'd0;
        foreach (status_seen[i]) status_seen[i] = 0;
        mismatches = 0;
        words_checked = 0;
    endfunction

    function void write_reg(t_reg_idx idx, logic [31:0] value);
        case (idx)
            REG_OWN_ID:  own_id = value[7:0];
            REG_TIMEOUT: timeout = value[15:0];
            default: ;
        endcase
    endfunction

    function int pending();
        return awaited_words.size();
    endfunction

    // Frames sent but not yet acknowledged, modulo the sequence space.
    function int window_fill(int r);
        logic [7:0] diff;
        diff = lfs[r] - lar[r];
        return int'(diff);
    endfunction

    // A timeout of zero still arms a timer with one tick.
    function logic [15:0] arm_value();
        return (timeout == 16'd0) ? 16'd1 : timeout;
    endfunction

    function void push_word(t_status st, logic [3:0] rcv, logic [7:0] seq);
        result_word_t w;
        w.status = st;
        w.rcv = rcv;
        w.seq = seq;
        w.last = 1'b0;
        awaited_words.push_back(w);
    endfunction

    // Length is checked first, then the receiver id, then the window.
    function void predict_send(swin_cmd_t c);
        logic [3:0] rcv;
        int fill;
        rcv = (c.dest < NUM_RECEIVERS) ? c.dest[3:0] : 4'd0;
        if (c.len > PAYLOAD_BYTES) begin
            push_word(ST_TOO_LONG, rcv, 8'd0);
        end else if (c.dest >= NUM_RECEIVERS) begin
            push_word(ST_BAD_RCV, 4'd0, 8'd0);
        end else begin
            fill = window_fill(int'(c.dest));
            if (fill >= WINDOW_SIZE) begin
                push_word(ST_WIN_FULL, rcv, 8'd0);
            end else begin
                lfs[c.dest] = lfs[c.dest] + 8'd1;
                slot_tmr[int'(c.dest) * WINDOW_SIZE + fill] = arm_value();
                push_word(ST_SENT, rcv, lfs[c.dest]);
            end
        end
    endfunction

    // An ack inside the open window slides it and shifts the timers down.
    function void predict_ack(swin_cmd_t c);
        logic [7:0] d;
        int src;
        int base;
        if (!c.crc) begin
            push_word(ST_CORRUPT, 4'd0, 8'd0);
        end else if (!c.flag) begin
            push_word(ST_NOT_ACK, 4'd0, 8'd0);
        end else if (c.tgt != own_id) begin
            push_word(ST_OTHER_TGT, 4'd0, 8'd0);
        end else if (c.src >= NUM_RECEIVERS) begin
            push_word(ST_BAD_RCV, 4'd0, 8'd0);
        end else begin
            src = int'(c.src);
            d = c.ackno - lar[src];
            if (d == 8'd0 || int'(d) > window_fill(src)) begin
                push_word(ST_ACK_STALE, c.src[3:0], 8'd0);
            end else begin
                base = src * WINDOW_SIZE;
                for (int k = 0; k < WINDOW_SIZE; k++) begin
                    slot_tmr[base + k] = (k + int'(d) < WINDOW_SIZE) ?
                                         slot_tmr[base + k + int'(d)] : 16'd0;
                end
                lar[src] = c.ackno;
                push_word(ST_ACK_SLID, c.src[3:0], 8'd0);
            end
        end
    endfunction

    // Every armed timer counts down; each expiry is a retransmit and rearms.
    function void predict_tick();
        int n;
        int idx;
        for (int r = 0; r < NUM_RECEIVERS; r++) begin
            n = window_fill(r);
            if (n > WINDOW_SIZE) n = WINDOW_SIZE;
            for (int k = 0; k < n; k++) begin
                idx = r * WINDOW_SIZE + k;
                if (slot_tmr[idx] != 16'd0) begin
                    slot_tmr[idx] = slot_tmr[idx] - 16'd1;
                    if (slot_tmr[idx] == 16'd0) begin
                        slot_tmr[idx] = arm_value();
                        push_word(ST_RETX, 4'(r), lar[r] + 8'(k) + 8'd1);
                    end
                end
            end
        end
    endfunction

    // Called once per accepted command; the final word of it carries last.
    function void note_cmd(swin_cmd_t c);
        int prior_count;
        prior_count = awaited_words.size();
        case (c.op)
            OP_SEND: predict_send(c);
            OP_ACK:  predict_ack(c);
            OP_TICK: predict_tick();
            default: ;
        endcase
        if (awaited_words.size() > prior_count)
            awaited_words[awaited_words.size() - 1].last = 1'b1;
    endfunction

    // Compares one result word with the oldest awaited one.
    function void check_word(logic [3:0] st, logic [3:0] rcv, logic [7:0] seq,
                             logic last);
        result_word_t w;
        words_checked++;
        status_seen[st]++;
        if (awaited_words.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected word: status %0d receiver %0d seq %0d last %0b",
                         st, rcv, seq, last);
            return;
        end
        w = awaited_words.pop_front();
        if (st !== w.status || rcv !== w.rcv || seq !== w.seq || last !== w.last) begin
            mismatches++;
            if (mismatches <= 10)
                $display("word %0d mismatch: expected %s rcv %0d seq %0d last %0b, %s",
                         words_checked, w.status.name(), w.rcv, w.seq, w.last,
                         $sformatf("got status %0d rcv %0d seq %0d last %0b",
                                   st, rcv, seq, last));
        end
    endfunction
endclass

module tb;
    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int QUIET_CYCLES = 80;
    localparam int PHASE_ITEMS = 31;

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                start;
    logic                busy;
    logic [1:0]          i_opcode;
    logic [7:0]          i_dest_receiver;
    logic [7:0]          i_message_length;
    logic                i_crc_good;
    logic                i_ack_flag_set;
    logic [7:0]          i_ack_target;
    logic [7:0]          i_ack_source;
    logic [7:0]          i_ack_number;
    logic                o_strobe;
    logic [3:0]          o_status;
    logic [3:0]          o_receiver;
    logic [7:0]          o_sequence_res;
    logic                o_last;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [APB_AW-1:0]   paddr;
    logic [APB_DW-1:0]   pwdata;
    logic [APB_DW-1:0]   prdata;
    logic                pready;

    window_result_board board;
    int                 cmds_issued = 0;

    sliding_window_sender DUT (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_opcode         (i_opcode),
        .i_dest_receiver  (i_dest_receiver),
        .i_message_length (i_message_length),
        .i_crc_good       (i_crc_good),
        .i_ack_flag_set   (i_ack_flag_set),
        .i_ack_target     (i_ack_target),
        .i_ack_source     (i_ack_source),
        .i_ack_number     (i_ack_number),
        .o_strobe         (o_strobe),
        .o_status         (o_status),
        .o_receiver       (o_receiver),
        .o_sequence_res   (o_sequence_res),
        .o_last           (o_last),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready)
    );

    // Clock with a 2 ns period.
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Every strobed word is taken at the rising edge that ends its cycle.
    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe)
            board.check_word(o_status, o_receiver, o_sequence_res, o_last);
    end

    // Drives one command and holds it until the block takes it.
    task automatic issue_cmd(input swin_cmd_t c);
        bit taken;
        taken = 1'b0;
        start <= 1'b1;
        i_opcode <= c.op;
        i_dest_receiver <= c.dest;
        i_message_length <= c.len;
        i_crc_good <= c.crc;
        i_ack_flag_set <= c.flag;
        i_ack_target <= c.tgt;
        i_ack_source <= c.src;
        i_ack_number <= c.ackno;
        while (!taken) begin
            @(posedge i_clk);
            taken = !busy;
        end
        board.note_cmd(c);
        cmds_issued++;
        @(negedge i_clk);
    endtask

    // Random gap with the given chance of idling in each cycle.
    task automatic idle_gap(input int pct);
        while ($urandom_range(0, 99) < pct) begin
            start <= 1'b0;
            @(negedge i_clk);
        end
    endtask

    // Holds off new commands until every awaited word has come.
    task automatic drain_results();
        start <= 1'b0;
        @(negedge i_clk);
        while (board.pending() > 0) @(negedge i_clk);
    endtask

    // A tick with no expiry gives no word, so allow a full scan to finish.
    task automatic wait_quiet();
        drain_results();
        repeat (QUIET_CYCLES) @(negedge i_clk);
        while (busy) @(negedge i_clk);
    endtask

    // Setup cycle, access cycle, then the bus idles before the next transfer.
    task automatic apb_write(input t_reg_idx idx, input logic [31:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= APB_AW'(4 * int'(idx));
        pwdata <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        board.write_reg(idx, value);
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic program_regs(input logic [7:0] id, input logic [15:0] ticks);
        apb_write(REG_OWN_ID, {24'd0, id});
        apb_write(REG_TIMEOUT, {16'd0, ticks});
    endtask

    function automatic swin_cmd_t mk_cmd(logic [1:0] op, logic [7:0] dest,
                                         logic [7:0] len, logic crc, logic flag,
                                         logic [7:0] tgt, logic [7:0] src,
                                         logic [7:0] ackno);
        swin_cmd_t c;
        c.op = op;
        c.dest = dest;
        c.len = len;
        c.crc = crc;
        c.flag = flag;
        c.tgt = tgt;
        c.src = src;
        c.ackno = ackno;
        return c;
    endfunction

    // Mostly well-formed sends and acks into the open windows, some ticks,
    // and a share of corrupt, misaddressed and unused commands.
    function automatic swin_cmd_t random_cmd(window_result_board b);
        swin_cmd_t c;
        int pick;
        int src;
        int fill;
        c = mk_cmd(2'($urandom), 8'($urandom), 8'($urandom), 1'($urandom),
                   1'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
        pick = $urandom_range(0, 99);
        if (pick < 40) begin
            c.op = OP_SEND;
            if ($urandom_range(0, 9) != 0) c.dest = 8'($urandom_range(0, NUM_RECEIVERS - 1));
            if ($urandom_range(0, 9) != 0) c.len = 8'($urandom_range(0, PAYLOAD_BYTES));
        end else if (pick < 75) begin
            c.op = OP_ACK;
            if ($urandom_range(0, 9) != 0) begin
                src = $urandom_range(0, NUM_RECEIVERS - 1);
                fill = b.window_fill(src);
                c.crc = 1'b1;
                c.flag = 1'b1;
                c.tgt = b.own_id;
                c.src = 8'(src);
                if (fill > 0 && $urandom_range(0, 9) < 8)
                    c.ackno = b.lar[src] + 8'($urandom_range(1, fill));
            end
        end else if (pick < 93) begin
            c.op = OP_TICK;
        end else if (pick < 97) begin
            c.op = OP_UNUSED;
        end
        return c;
    endfunction

    task automatic run_phase(input int idle_pct, input int count);
        for (int i = 0; i < count; i++) begin
            issue_cmd(random_cmd(board));
            if ($urandom_range(0, 49) == 0) drain_results();
            else idle_gap(idle_pct);
        end
    endtask

    // Stimulus: directed cases, then three random phases with different
    // register settings and sender idling.
    initial begin
        board = new();
        i_rst_n = 1'b0;
        start = 1'b0;
        i_opcode = OP_SEND;
        i_dest_receiver = 8'd0;
        i_message_length = 8'd0;
        i_crc_good = 1'b0;
        i_ack_flag_set = 1'b0;
        i_ack_target = 8'd0;
        i_ack_source = 8'd0;
        i_ack_number = 8'd0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: refusal order for sends, every ack check, one retransmit,
        // the unused opcode, a full window and a slide over the whole window.
        program_regs(8'hA5, 16'd2);
        issue_cmd(mk_cmd(OP_SEND, 8'd0, 8'd49, 0, 0, 0, 0, 0));
        issue_cmd(mk_cmd(OP_SEND, 8'd3, 8'd255, 0, 0, 0, 0, 0));
        issue_cmd(mk_cmd(OP_SEND, 8'd200, 8'd255, 0, 0, 0, 0, 0));
        issue_cmd(mk_cmd(OP_SEND, 8'd255, 8'd0, 0, 0, 0, 0, 0));
        issue_cmd(mk_cmd(OP_SEND, 8'd0, 8'd48, 0, 0, 0, 0, 0));
        issue_cmd(mk_cmd(OP_SEND, 8'd3, 8'd0, 0, 0, 0, 0, 0));
        issue_cmd(mk_cmd(OP_ACK, 0, 0, 1'b0, 1'b1, 8'hA5, 8'd0, 8'd1));
        issue_cmd(mk_cmd(OP_ACK, 0, 0, 1'b1, 1'b0, 8'hA5, 8'd0, 8'd1));
        issue_cmd(mk_cmd(OP_ACK, 0, 0, 1'b1, 1'b1, 8'h5A, 8'd0, 8'd1));
        issue_cmd(mk_cmd(OP_ACK, 0, 0, 1'b1, 1'b1, 8'hA5, 8'd255, 8'd1));
        issue_cmd(mk_cmd(OP_ACK, 0, 0, 1'b1, 1'b1, 8'hA5, 8'd1, 8'd0));
        issue_cmd(mk_cmd(OP_ACK, 0, 0, 1'b1, 1'b1, 8'hA5, 8'd0, 8'd1));
        issue_cmd(mk_cmd(OP_TICK, 0, 0, 0, 0, 0, 0, 0));
        issue_cmd(mk_cmd(OP_TICK, 0, 0, 0, 0, 0, 0, 0));
        issue_cmd(mk_cmd(OP_UNUSED, 0, 0, 0, 0, 0, 0, 0));
        for (int i = 0; i <= WINDOW_SIZE; i++)
            issue_cmd(mk_cmd(OP_SEND, 8'd2, 8'd17, 0, 0, 0, 0, 0));
        issue_cmd(mk_cmd(OP_ACK, 0, 0, 1'b1, 1'b1, 8'hA5, 8'd2, 8'd0));
        issue_cmd(mk_cmd(OP_ACK, 0, 0, 1'b1, 1'b1, 8'hA5, 8'd2, 8'd255));
        issue_cmd(mk_cmd(OP_ACK, 0, 0, 1'b1, 1'b1, 8'hA5, 8'd2, 8'(WINDOW_SIZE)));

        // Random phases; a zero timeout arms each new timer with one tick, so it expires on the next tick.
        wait_quiet();
        program_regs(8'hFF, 16'd0);
        run_phase(37, PHASE_ITEMS);
        wait_quiet();
        program_regs(8'h00, 16'd3);
        run_phase(85, PHASE_ITEMS);
        wait_quiet();
        program_regs(8'($urandom), 16'hFFFF);
        run_phase(0, PHASE_ITEMS);

        drain_results();
        repeat (QUIET_CYCLES) @(negedge i_clk);

        $display("ran %0d commands, checked %0d words: %0d sent, %0d retransmits",
                 cmds_issued, board.words_checked, board.status_seen[ST_SENT],
                 board.status_seen[ST_RETX]);
        $display("acks slid %0d, stale %0d, full windows %0d, mismatches %0d",
                 board.status_seen[ST_ACK_SLID], board.status_seen[ST_ACK_STALE],
                 board.status_seen[ST_WIN_FULL], board.mismatches);
        if (board.mismatches == 0 && board.pending() == 0) begin
            $display("status: pass");
        end else begin
            if (board.pending() > 0)
                $display("%0d result words never arrived", board.pending());
            $display("status: fail");
        end
        $finish;
    end

    // Watchdog for a hung handshake.
    initial begin
        #1000000;
        $display("run timed out with %0d words outstanding", board.pending());
        $display("status: fail");
        $finish;
    end
endmodule
